// File: rtl/frame_delta_smoother_assert.svh
// Assertion macros shared by the frame delta smoother RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FRAME_DELTA_SMOOTHER_ASSERT_SVH
`define FRAME_DELTA_SMOOTHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define FDS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame_delta_smoother: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define FDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame_delta_smoother: next-cycle check failed");

// Expression must never be true out of reset
`define FDS_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("frame_delta_smoother: forbidden condition seen");

`endif

// File: rtl/fds_pkg.sv
// Shared constants and controller/datapath interface types for the frame delta smoother.
// No dependencies; used by fds_ctrl, fds_dp and frame_delta_smoother.
`default_nettype none

package fds_pkg;

    // Field and register widths
    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 32;
    localparam int GROUP_W  = 4;
    localparam int DELTA_W  = 35;
    localparam int ACC_W    = 36;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Long-frame limit is 8 periods, resync level is 2 periods
    localparam int LIMIT_SHIFT  = 3;
    localparam int RESYNC_SHIFT = 1;
    localparam int GROUP_MAX    = 8;

    // History of recent deltas; depth must stay a power of two (average is a shift)
    localparam int HIST_DEPTH = 4;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam int SUM_W      = DELTA_W + HIST_IDX_W;

    // Snap candidates: snap_period * k, k = 1..SNAP_COUNT
    localparam int SNAP_COUNT = 8;
    localparam int SNAP_IDX_W = (SNAP_COUNT > 1) ? $clog2(SNAP_COUNT) : 1;
    localparam int CAND_W     = PERIOD_W + $clog2(SNAP_COUNT + 1);
    localparam int DIST_W     = (CAND_W > DELTA_W) ? CAND_W : DELTA_W;

    // Update unit = period * group
    localparam int UNIT_W = PERIOD_W + GROUP_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_GROUP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_PERIOD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_TOLERANCE = 2'd3;

    // Configuration reset values
    localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST   = 32'd166667;
    localparam logic [GROUP_W-1:0]  UPDATE_GROUP_RST   = 4'd1;
    localparam logic [PERIOD_W-1:0] SNAP_PERIOD_RST    = 32'd166667;
    localparam logic [PERIOD_W-1:0] SNAP_TOLERANCE_RST = 32'd2000;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;     // take timestamp, form clamped delta
        logic snap_step;   // try one snap candidate
        logic hist_write;  // store delta in history, clear sum
        logic sum_step;    // add one history entry to sum
        logic avg_step;    // divide sum, carry remainder
        logic acc_add;     // add delta to accumulator
        logic resync_chk;  // resync if needed, form update unit
        logic count_step;  // remove one update group from accumulator
        logic out_load;    // capture result into output registers
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic snap_last;   // current candidate is the last one
        logic sum_last;    // current history entry is the last one
        logic count_done;  // accumulator below one update unit
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/fds_ctrl.sv
// Sequencing controller for the frame delta smoother.
// Depends on fds_pkg (command/status types) and frame_delta_smoother_assert.svh.
`default_nettype none
`include "frame_delta_smoother_assert.svh"

module fds_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output fds_pkg::ctrl_cmd_t       cmd,
    input  wire fds_pkg::dp_status_t st
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SNAP   = 4'd1;
    localparam logic [3:0] S_HIST   = 4'd2;
    localparam logic [3:0] S_SUM    = 4'd3;
    localparam logic [3:0] S_AVG    = 4'd4;
    localparam logic [3:0] S_ACC    = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_COUNT  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SNAP;
                end
            end
            S_SNAP:
            begin
                cmd.snap_step = 1'b1;
                if (st.snap_last)
                begin
                    state_next = S_HIST;
                end
            end
            S_HIST:
            begin
                cmd.hist_write = 1'b1;
                state_next     = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (st.sum_last)
                begin
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                cmd.avg_step = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.resync_chk = 1'b1;
                state_next     = S_COUNT;
            end
            S_COUNT:
            begin
                if (st.count_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.count_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FDS_ASSERT_NEXT(a_done_holds, (state_reg == S_DONE) && out_valid_reg && !out_ready, state_reg == S_DONE)
    `FDS_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, out_valid_reg)
    `FDS_ASSERT_NEXT(a_snap_exit, (state_reg == S_SNAP) && st.snap_last, state_reg == S_HIST)

endmodule

`default_nettype wire

// File: rtl/fds_dp.sv
// Datapath of the frame delta smoother: config registers, delta, snap, history, accumulator.
// Depends on fds_pkg (constants, command/status types) and frame_delta_smoother_assert.svh.
`default_nettype none
`include "frame_delta_smoother_assert.svh"

module fds_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [fds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [fds_pkg::PERIOD_W-1:0]        cfg_data,
    input  wire logic [fds_pkg::TIME_W-1:0]          timestamp,
    input  wire fds_pkg::ctrl_cmd_t                  cmd,
    output fds_pkg::dp_status_t                      st,
    output logic [fds_pkg::DELTA_W-1:0]              smoothed_delta,
    output logic [fds_pkg::COUNT_W-1:0]              update_count,
    output logic                                     resynced
);

    localparam int TW  = fds_pkg::TIME_W;
    localparam int PW  = fds_pkg::PERIOD_W;
    localparam int GW  = fds_pkg::GROUP_W;
    localparam int DW  = fds_pkg::DELTA_W;
    localparam int AW  = fds_pkg::ACC_W;
    localparam int CW  = fds_pkg::COUNT_W;
    localparam int HD  = fds_pkg::HIST_DEPTH;
    localparam int HW  = fds_pkg::HIST_IDX_W;
    localparam int SW  = fds_pkg::SUM_W;
    localparam int KW  = fds_pkg::SNAP_IDX_W;
    localparam int NW  = fds_pkg::CAND_W;
    localparam int XW  = fds_pkg::DIST_W;
    localparam int UW  = fds_pkg::UNIT_W;

    // Configuration registers
    logic [PW-1:0] frame_period_reg;
    logic [GW-1:0] update_group_reg;
    logic [PW-1:0] snap_period_reg;
    logic [PW-1:0] snap_tolerance_reg;

    // Frame state
    logic [TW-1:0] prev_time_reg;
    logic [DW-1:0] hist_reg [HD];
    logic [HW-1:0] slot_reg;
    logic [HW-1:0] avg_rem_reg;
    logic [AW-1:0] acc_reg;
    logic          pend_reg;

    // Work registers
    logic [DW-1:0] delta_reg;
    logic [NW-1:0] cand_reg;
    logic [KW-1:0] snap_idx_reg;
    logic [SW-1:0] sum_reg;
    logic [HW-1:0] sum_idx_reg;
    logic [UW-1:0] unit_reg;
    logic [CW-1:0] count_reg;
    logic          resync_flag_reg;

    // Output registers
    logic [DW-1:0] smoothed_delta_reg;
    logic [CW-1:0] update_count_reg;
    logic          resynced_reg;

    // Effective period, group and limits
    logic [PW-1:0] fp_eff;
    logic [GW-1:0] g_eff;
    logic [DW-1:0] limit;
    logic [TW-1:0] raw_delta;
    logic [DW-1:0] clamped_delta;
    logic [XW-1:0] cand_x;
    logic [XW-1:0] delta_x;
    logic [XW-1:0] snap_dist;
    logic          cand_ok;
    logic          snap_hit;
    logic [HW:0]   rem_sum;
    logic          resync_cond;

    assign fp_eff = (frame_period_reg == '0) ? PW'(1) : frame_period_reg;

    always_comb
    begin
        if (update_group_reg == '0)
        begin
            g_eff = GW'(1);
        end
        else if (update_group_reg > GW'(fds_pkg::GROUP_MAX))
        begin
            g_eff = GW'(fds_pkg::GROUP_MAX);
        end
        else
        begin
            g_eff = update_group_reg;
        end
    end

    assign limit = DW'(fp_eff) << fds_pkg::LIMIT_SHIFT;

    // Wrap-safe delta, clamped to the long-frame limit
    assign raw_delta     = timestamp - prev_time_reg;
    assign clamped_delta = (raw_delta > TW'(limit)) ? limit : raw_delta[DW-1:0];

    // One snap candidate per cycle
    assign cand_x    = XW'(cand_reg);
    assign delta_x   = XW'(delta_reg);
    assign cand_ok   = (cand_x <= XW'(limit));
    assign snap_dist = (delta_x > cand_x) ? (delta_x - cand_x) : (cand_x - delta_x);
    assign snap_hit  = cand_ok && (snap_dist < XW'(snap_tolerance_reg));

    // Remainder carry for the average
    assign rem_sum = {1'b0, avg_rem_reg} + {1'b0, sum_reg[HW-1:0]};

    assign resync_cond = pend_reg || (acc_reg > AW'(limit));

    // Status to controller
    assign st.snap_last  = (snap_idx_reg == KW'(fds_pkg::SNAP_COUNT - 1));
    assign st.sum_last   = (sum_idx_reg == HW'(HD - 1));
    assign st.count_done = (UW'(acc_reg) < unit_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_period_reg   <= fds_pkg::FRAME_PERIOD_RST;
            update_group_reg   <= fds_pkg::UPDATE_GROUP_RST;
            snap_period_reg    <= fds_pkg::SNAP_PERIOD_RST;
            snap_tolerance_reg <= fds_pkg::SNAP_TOLERANCE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fds_pkg::CFG_FRAME_PERIOD:   frame_period_reg   <= cfg_data;
                fds_pkg::CFG_UPDATE_GROUP:   update_group_reg   <= cfg_data[GW-1:0];
                fds_pkg::CFG_SNAP_PERIOD:    snap_period_reg    <= cfg_data;
                fds_pkg::CFG_SNAP_TOLERANCE: snap_tolerance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Frame state: previous stamp, history, remainder, accumulator, resync flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            for (int i = 0; i < HD; i++)
            begin
                hist_reg[i] <= '0;
            end
            slot_reg        <= '0;
            avg_rem_reg     <= '0;
            acc_reg         <= '0;
            pend_reg        <= 1'b1;
            count_reg       <= '0;
            resync_flag_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                prev_time_reg <= timestamp;
            end
            if (cmd.hist_write)
            begin
                hist_reg[slot_reg] <= delta_reg;
                slot_reg           <= slot_reg + HW'(1);
            end
            if (cmd.avg_step)
            begin
                avg_rem_reg <= rem_sum[HW-1:0];
            end
            if (cmd.acc_add)
            begin
                acc_reg <= acc_reg + AW'(delta_reg);
            end
            if (cmd.resync_chk)
            begin
                count_reg       <= '0;
                resync_flag_reg <= resync_cond;
                if (resync_cond)
                begin
                    acc_reg <= AW'(fp_eff) << fds_pkg::RESYNC_SHIFT;
                    for (int i = 0; i < HD; i++)
                    begin
                        hist_reg[i] <= DW'(fp_eff);
                    end
                    slot_reg <= '0;
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.count_step)
            begin
                acc_reg   <= acc_reg - AW'(unit_reg);
                count_reg <= count_reg + CW'(g_eff);
            end
        end
    end

    // Work registers: delta, snap sweep, history sum, update unit
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            delta_reg    <= clamped_delta;
            cand_reg     <= NW'(snap_period_reg);
            snap_idx_reg <= '0;
        end
        if (cmd.snap_step)
        begin
            if (snap_hit)
            begin
                delta_reg <= cand_reg[DW-1:0];
            end
            cand_reg     <= cand_reg + NW'(snap_period_reg);
            snap_idx_reg <= snap_idx_reg + KW'(1);
        end
        if (cmd.hist_write)
        begin
            sum_reg     <= '0;
            sum_idx_reg <= '0;
        end
        if (cmd.sum_step)
        begin
            sum_reg     <= sum_reg + SW'(hist_reg[sum_idx_reg]);
            sum_idx_reg <= sum_idx_reg + HW'(1);
        end
        if (cmd.avg_step)
        begin
            delta_reg <= sum_reg[SW-1:HW] + DW'(rem_sum[HW]);
        end
        if (cmd.resync_chk)
        begin
            unit_reg <= UW'(fp_eff) * UW'(g_eff);
            if (resync_cond)
            begin
                delta_reg <= DW'(fp_eff);
            end
        end
    end

    // Output registers
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            smoothed_delta_reg <= delta_reg;
            update_count_reg   <= count_reg;
            resynced_reg       <= resync_flag_reg;
        end
    end

    assign smoothed_delta = smoothed_delta_reg;
    assign update_count   = update_count_reg;
    assign resynced       = resynced_reg;

    `FDS_ASSERT_NEVER(a_count_range, count_reg > CW'(fds_pkg::GROUP_MAX))
    `FDS_ASSERT_IMPL(a_acc_below_unit, cmd.out_load, UW'(acc_reg) < unit_reg)
    `FDS_ASSERT_NEXT(a_resync_clears, cmd.resync_chk && resync_cond, (slot_reg == '0) && !pend_reg)

endmodule

`default_nettype wire

// File: rtl/frame_delta_smoother.sv
// Top level of the frame delta smoother: joins controller and datapath.
// Depends on fds_pkg, fds_ctrl and fds_dp.
`default_nettype none

// Frame delta smoother. One timestamp transfer per displayed frame gives one result transfer
// (smoothed_delta, update_count, resynced). Items are processed one at a time: after the input
// transfer an item passes through the snap sweep (one snap_period multiple tried per cycle),
// the history write, the history sum (one entry per cycle), the average, the accumulate, the
// resync check and the update-count loop (one group subtracted per cycle; it removes n update
// groups from the accumulator, n in 0..8). A finished result sits in an output register, so
// the next timestamp is taken while the previous result waits. Configuration writes
// (cfg_index 0..3: frame_period, update_group, snap_period, snap_tolerance) take effect at
// once and must only be issued while the block is idle.
module frame_delta_smoother (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [fds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fds_pkg::PERIOD_W-1:0]    cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [fds_pkg::TIME_W-1:0]      timestamp,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [fds_pkg::DELTA_W-1:0]          smoothed_delta,
    output logic [fds_pkg::COUNT_W-1:0]          update_count,
    output logic                                 resynced
);

    fds_pkg::ctrl_cmd_t cmd;
    fds_pkg::dp_status_t st;

    // Sequencer
    fds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

    // Arithmetic and state
    fds_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .timestamp      (timestamp),
        .cmd            (cmd),
        .st             (st),
        .smoothed_delta (smoothed_delta),
        .update_count   (update_count),
        .resynced       (resynced)
    );

endmodule

`default_nettype wire
